/* hdl/llpe_pkg.sv */
// ----------------------------------------------------------------------------
// llpe_pkg
// shared constants, codes and word types for the line list pick engine
// ----------------------------------------------------------------------------
package llpe_pkg;

  localparam int MAX_LINES  = 64;
  localparam int COORD_BITS = 12;
  localparam int POS_W      = 12;
  localparam int LIDX_W     = 6;
  localparam int LCNT_W     = 7;
  localparam int TOL_W      = 8;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam int IDX_W    = $clog2(MAX_LINES);
  localparam int CNT_W    = $clog2(MAX_LINES + 1);
  localparam int CMP_W    = (CNT_W > LIDX_W) ? CNT_W : LIDX_W;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int LHS_W    = PROD_W + 1;
  localparam int TABS_W   = TOL_W + COORD_BITS;
  localparam int HIT_LAT  = 3;
  localparam int SCAN_END = MAX_LINES + HIT_LAT;
  localparam int SCAN_W   = $clog2(SCAN_END + 1);

  localparam logic [1:0] CMD_PLACE  = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SELECT = 2'd2;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;
  localparam logic [1:0] STS_NOHIT   = 2'd3;

  localparam logic [CFG_AW-3:0] REG_TOL = '0;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
  } seg_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [LIDX_W-1:0] line_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LIDX_W-1:0] hit_index;
    logic [LCNT_W-1:0] line_count;
    logic              start_pending;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } hit_req_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } hit_rsp_t;

endpackage

/* hdl/llpe_cell.sv */
// ----------------------------------------------------------------------------
// llpe_cell
// one entry of the line chain: holds, loads a new line or takes its neighbor
// ----------------------------------------------------------------------------
module llpe_cell (
  input  logic               clk,
  input  llpe_pkg::cell_op_t op,
  input  llpe_pkg::seg_t     next_seg,
  input  llpe_pkg::seg_t     new_seg,
  output llpe_pkg::seg_t     seg
);
  import llpe_pkg::*;

  seg_t seg_r;
  seg_t seg_nxt;

  always_comb begin
    case (op)
      CELL_SHIFT: seg_nxt = next_seg;
      CELL_LOAD:  seg_nxt = new_seg;
      default:    seg_nxt = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;

endmodule

/* hdl/llpe_hit.sv */
// ----------------------------------------------------------------------------
// llpe_hit
// three stage pick test: |(y-y1)dx - (x-x1)dy| <= tol*|dx|, dx != 0
// ----------------------------------------------------------------------------
module llpe_hit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  llpe_pkg::hit_req_t            req,
  input  llpe_pkg::seg_t                seg,
  input  llpe_pkg::coord_t              px,
  input  llpe_pkg::coord_t              py,
  input  logic [llpe_pkg::TOL_W-1:0]    tol,
  output llpe_pkg::hit_rsp_t            rsp
);
  import llpe_pkg::*;

  // stage 1: differences
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, ex_nxt, ey_nxt;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, ex1_r, ey1_r;
  logic                     v1_r;
  logic [IDX_W-1:0]         idx1_r;
  logic [TOL_W-1:0]         tol1_r;

  assign dx_nxt = signed'({1'b0, seg.xb}) - signed'({1'b0, seg.xa});
  assign dy_nxt = signed'({1'b0, seg.yb}) - signed'({1'b0, seg.ya});
  assign ex_nxt = signed'({1'b0, px}) - signed'({1'b0, seg.xa});
  assign ey_nxt = signed'({1'b0, py}) - signed'({1'b0, seg.ya});

  // stage 2: products
  logic signed [DIFF_W-1:0] ndx;
  logic [COORD_BITS-1:0]    adx;
  logic signed [PROD_W-1:0] p1_nxt, p2_nxt, p1_r, p2_r;
  logic [TABS_W-1:0]        tabs_nxt, tabs_r;
  logic                     v2_r, nz2_r;
  logic [IDX_W-1:0]         idx2_r;

  assign ndx      = -dx1_r;
  assign adx      = dx1_r[DIFF_W-1] ? ndx[COORD_BITS-1:0] : dx1_r[COORD_BITS-1:0];
  assign p1_nxt   = PROD_W'(ey1_r) * PROD_W'(dx1_r);
  assign p2_nxt   = PROD_W'(ex1_r) * PROD_W'(dy1_r);
  assign tabs_nxt = {{COORD_BITS{1'b0}}, tol1_r} * {{TOL_W{1'b0}}, adx};

  // stage 3: compare
  logic signed [LHS_W-1:0] lhs, nlhs;
  logic [LHS_W-1:0]        alhs;
  logic                    hit_nxt;
  logic                    v3_r, hit3_r;
  logic [IDX_W-1:0]        idx3_r;

  assign lhs     = LHS_W'(p1_r) - LHS_W'(p2_r);
  assign nlhs    = -lhs;
  assign alhs    = lhs[LHS_W-1] ? nlhs[LHS_W-1:0] : lhs[LHS_W-1:0];
  assign hit_nxt = nz2_r && (alhs <= LHS_W'(tabs_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    dx1_r  <= dx_nxt;
    dy1_r  <= dy_nxt;
    ex1_r  <= ex_nxt;
    ey1_r  <= ey_nxt;
    idx1_r <= req.idx;
    tol1_r <= tol;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    tabs_r <= tabs_nxt;
    nz2_r  <= (dx1_r != '0);
    idx2_r <= idx1_r;
    hit3_r <= hit_nxt;
    idx3_r <= idx2_r;
  end

  assign rsp.valid = v3_r;
  assign rsp.hit   = hit3_r;
  assign rsp.idx   = idx3_r;

endmodule

/* hdl/line_list_pick_engine.sv */
// ----------------------------------------------------------------------------
// line_list_pick_engine
// line list with place, remove and select commands over a chain of cells
// ----------------------------------------------------------------------------
// place and remove: the result is registered; the finish state moves it to the output register
// once that is free and returns to idle for the next word; select first makes one full turn of
//   the cell ring past the single pick test unit (3 stages), and an empty list skips the scan
// one command at a time; the next word is taken while a result waits
// synchronous active-low reset clears control state, tolerance goes to 12
// line entries are not cleared and are never read before being written
module line_list_pick_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  llpe_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output llpe_pkg::out_word_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [llpe_pkg::CFG_AW-1:0]       paddr,
  input  logic [llpe_pkg::CFG_DW-1:0]       pwdata,
  output logic [llpe_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);
  import llpe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } fsm_t;

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r, pend_nxt;
  coord_t           pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [TOL_W-1:0] tol_r;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  coord_t           px_r, px_nxt, py_r, py_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  out_word_t        res_r, res_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic   in_fire, full, idx_ok, load_en, rm_en, rotate;
  coord_t pos_x_c, pos_y_c;
  seg_t   new_seg;
  seg_t   seg [MAX_LINES];
  hit_req_t hreq;
  hit_rsp_t hrsp;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pos_x_c  = coord_t'(in_data.pos_x);
  assign pos_y_c  = coord_t'(in_data.pos_y);
  assign full     = (count_r == CNT_W'(MAX_LINES));
  assign idx_ok   = CMP_W'(in_data.line_index) < CMP_W'(count_r);
  assign load_en  = in_fire && (in_data.cmd == CMD_PLACE) && !full && pend_r;
  assign rm_en    = in_fire && (in_data.cmd == CMD_REMOVE) && idx_ok;
  assign rotate   = (state_r == S_SCAN) && (scan_r < SCAN_W'(MAX_LINES));
  assign new_seg  = '{xa: pend_x_r, ya: pend_y_r, xb: pos_x_c, yb: pos_y_c};

  // cell ring
  for (genvar i = 0; i < MAX_LINES; i++) begin : g_cell
    cell_op_t op;
    always_comb begin
      if (rotate) begin
        op = CELL_SHIFT;
      end else if (load_en && (count_r == CNT_W'(i))) begin
        op = CELL_LOAD;
      end else if (rm_en && (i < MAX_LINES - 1) &&
                   (CMP_W'(i) >= CMP_W'(in_data.line_index))) begin
        op = CELL_SHIFT;
      end else begin
        op = CELL_HOLD;
      end
    end
    llpe_cell u_cell (
      .clk      (clk),
      .op       (op),
      .next_seg (seg[(i + 1) % MAX_LINES]),
      .new_seg  (new_seg),
      .seg      (seg[i])
    );
  end

  assign hreq.valid = rotate && (scan_r < SCAN_W'(count_r));
  assign hreq.idx   = scan_r[IDX_W-1:0];

  llpe_hit u_hit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .seg   (seg[0]),
    .px    (px_r),
    .py    (py_r),
    .tol   (tol_r),
    .rsp   (hrsp)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    scan_nxt      = scan_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.status    = STS_INVALID;
          res_nxt.hit_index = '0;
          state_nxt         = S_FIN;
          case (in_data.cmd)
            CMD_PLACE: begin
              if (full) begin
                res_nxt.status = STS_FULL;
              end else if (!pend_r) begin
                pend_nxt       = 1'b1;
                pend_x_nxt     = pos_x_c;
                pend_y_nxt     = pos_y_c;
                res_nxt.status = STS_DONE;
              end else begin
                pend_nxt       = 1'b0;
                count_nxt      = count_r + 1'b1;
                res_nxt.status = STS_DONE;
              end
            end
            CMD_REMOVE: begin
              if (idx_ok) begin
                count_nxt      = count_r - 1'b1;
                res_nxt.status = STS_DONE;
              end
            end
            CMD_SELECT: begin
              if (count_r != '0) begin
                px_nxt    = pos_x_c;
                py_nxt    = pos_y_c;
                scan_nxt  = '0;
                found_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt.status = STS_INVALID;
            end
          endcase
          res_nxt.line_count    = LCNT_W'(count_nxt);
          res_nxt.start_pending = pend_nxt;
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (hrsp.valid && hrsp.hit && !found_r) begin
          found_nxt = 1'b1;
          fidx_nxt  = hrsp.idx;
        end
        if (scan_r == SCAN_W'(SCAN_END)) begin
          res_nxt.status    = found_r ? STS_DONE : STS_NOHIT;
          res_nxt.hit_index = found_r ? LIDX_W'(fidx_r) : '0;
          state_nxt         = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      pend_x_r    <= '0;
      pend_y_r    <= '0;
      tol_r       <= TOL_W'(12);
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      pend_x_r    <= pend_x_nxt;
      pend_y_r    <= pend_y_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      scan_r      <= scan_nxt;
      if (psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_TOL)) begin
        tol_r <= pwdata[TOL_W-1:0];
      end
    end
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    fidx_r <= fidx_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // config read
  assign prdata = (paddr[CFG_AW-1:2] == REG_TOL) ? CFG_DW'(tol_r) : '0;
  assign pready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/llpe_checker.sv */
// ----------------------------------------------------------------------------
// llpe_checker
// port level checks for the line list pick engine, bound to the top level
// ----------------------------------------------------------------------------
module llpe_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input llpe_pkg::out_word_t  out_data
);
  import llpe_pkg::*;

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one command in flight: no word taken right after another
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // hit index only set on a successful pick
  a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STS_DONE) |-> (out_data.hit_index == '0))
    else $error("hit index set without a hit");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_list_pick_engine llpe_checker u_llpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
